### rtl/crfw_pkg.sv
`timescale 1ns / 1ps

package crfw_pkg;

	// field and register widths
	localparam int COORD_W    = 16;
	localparam int END_W      = COORD_W + 1;
	localparam int ADDR_W     = 48;
	localparam int PITCH_W    = 18;
	localparam int FMT_W      = 10;
	localparam int CHAN_W     = 8;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = COORD_W + PITCH_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ADDR_W;

	// stream payload widths, already whole bytes
	localparam int IN_TDATA_W  = 4 * COORD_W + 3 * CHAN_W;
	localparam int OUT_TDATA_W = ADDR_W + WORD_W;

	// register reset values
	localparam logic [FMT_W-1:0] RED_FORMAT_RST   = FMT_W'(520);
	localparam logic [FMT_W-1:0] GREEN_FORMAT_RST = FMT_W'(264);
	localparam logic [FMT_W-1:0] BLUE_FORMAT_RST  = FMT_W'(8);

	// item kinds carried in tuser
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS  = 3'd0,
		REG_SCREEN_WIDTH  = 3'd1,
		REG_SCREEN_HEIGHT = 3'd2,
		REG_ROW_PITCH     = 3'd3,
		REG_RED_FORMAT    = 3'd4,
		REG_GREEN_FORMAT  = 3'd5,
		REG_BLUE_FORMAT   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  base_address;
		logic [COORD_W-1:0] screen_width;
		logic [COORD_W-1:0] screen_height;
		logic [PITCH_W-1:0] row_pitch;
		logic [FMT_W-1:0]   red_format;
		logic [FMT_W-1:0]   green_format;
		logic [FMT_W-1:0]   blue_format;
	} cfg_t;

	// input beat layout, rect_x in the lowest bits
	typedef struct packed {
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  red;
		logic [COORD_W-1:0] rect_height;
		logic [COORD_W-1:0] rect_width;
		logic [COORD_W-1:0] rect_y;
		logic [COORD_W-1:0] rect_x;
	} in_item_t;

	// prepared item handed to the walker
	typedef struct packed {
		logic               is_tick;
		logic               start_ok;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [END_W-1:0]   end_col;
		logic [END_W-1:0]   end_row;
		logic [WORD_W-1:0]  fill_word;
		logic [PROD_W-1:0]  y_pitch;
	} prep_t;

	// scale v to v*(2^size-1)/255 and shift into place
	// with size = 8k+j: v*(2^size-1)/255 = v*2^j*0x0101.. (k bytes) + v*(2^j-1)/255
	function automatic logic [WORD_W-1:0] place_channel(input logic [CHAN_W-1:0] v,
			input logic [FMT_W-1:0] fmt);
		logic [4:0]            size;
		logic [4:0]            shift;
		logic [1:0]            k;
		logic [2:0]            j;
		logic [3*CHAN_W-1:0]   rep;
		logic [WORD_W-2:0]     hi;
		logic [2*CHAN_W-1:0]   lo_n;
		logic [2*CHAN_W:0]     lo_sum;
		logic [CHAN_W-1:0]     lo;
		logic [WORD_W-1:0]     q;
		size = fmt[4:0];
		shift = fmt[9:5];
		k = size[4:3];
		j = size[2:0];
		unique case (k)
			2'd0: rep = '0;
			2'd1: rep = {{(2*CHAN_W){1'b0}}, v};
			2'd2: rep = {{CHAN_W{1'b0}}, v, v};
			2'd3: rep = {v, v, v};
		endcase
		hi = (WORD_W-1)'(rep) << j;
		lo_n = ((2*CHAN_W)'(v) << j) - (2*CHAN_W)'(v);
		// exact divide by 255 for 16-bit values below 65535
		lo_sum = (2*CHAN_W+1)'(lo_n) + (2*CHAN_W+1)'(1) + (2*CHAN_W+1)'(lo_n[2*CHAN_W-1:CHAN_W]);
		lo = lo_sum[2*CHAN_W-1:CHAN_W];
		q = WORD_W'(hi) + WORD_W'(lo);
		return q << shift;
	endfunction

endpackage

### rtl/crfw_prep.sv
`timescale 1ns / 1ps

module crfw_prep import crfw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_mode,
	input  logic [IN_TDATA_W-1:0] in_data,
	output logic                  out_valid,
	output prep_t                 out_item,
	input  logic                  out_take
);

	logic     valid_s1;
	logic     mode_s1;
	in_item_t item_s1;
	logic     valid_s2;
	prep_t    item_s2;
	logic     ready_s2;
	prep_t    prep_c;

	logic [COORD_W-1:0] avail_w;
	logic [COORD_W-1:0] avail_h;
	logic [COORD_W-1:0] w_clip;
	logic [COORD_W-1:0] h_clip;

	// elastic handshake between the two stages
	assign ready_s2 = !valid_s2 || out_take;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= in_mode;
			item_s1 <= in_item_t'(in_data);
		end
	end

	// clip against the screen, encode the color, row offset product
	always_comb begin
		avail_w = cfg.screen_width - item_s1.rect_x;
		avail_h = cfg.screen_height - item_s1.rect_y;
		w_clip = (item_s1.rect_width > avail_w) ? avail_w : item_s1.rect_width;
		h_clip = (item_s1.rect_height > avail_h) ? avail_h : item_s1.rect_height;
		prep_c.is_tick = (mode_s1 == MODE_TICK);
		prep_c.start_ok = (item_s1.rect_x < cfg.screen_width)
			&& (item_s1.rect_y < cfg.screen_height)
			&& (item_s1.rect_width != '0) && (item_s1.rect_height != '0);
		prep_c.x = item_s1.rect_x;
		prep_c.y = item_s1.rect_y;
		prep_c.end_col = END_W'(item_s1.rect_x) + END_W'(w_clip);
		prep_c.end_row = END_W'(item_s1.rect_y) + END_W'(h_clip);
		prep_c.fill_word = place_channel(item_s1.red, cfg.red_format)
			| place_channel(item_s1.green, cfg.green_format)
			| place_channel(item_s1.blue, cfg.blue_format);
		prep_c.y_pitch = PROD_W'(item_s1.rect_y) * PROD_W'(cfg.row_pitch);
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1)
			item_s2 <= prep_c;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

### rtl/clipped_rectangle_fill_writer.sv
`timescale 1ns / 1ps

// Rectangle fill writer for a 32-bit RGB framebuffer.
// Slave stream: tuser is the item kind (start or tick), tdata the rectangle
// and its color (8-bit channels). A start latches the clipped rectangle and
// encoded pixel word and emits nothing; each later tick emits one pixel write
// beat on the master stream (address, pixel word, tlast on the final pixel).
// Ticks while no fill is running and starts with an off-screen corner or
// zero size produce no beat. A new start drops the fill in progress.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// The user must keep to this; the block does not enforce it. Throughput:
// one item per cycle while the receiver keeps up; the pipeline is an input
// register, a prepare stage (clip, channel scaling, one 16x18 multiply) and
// the walker stage that loads the output register. Reset clears all
// configuration to its defaults, stops any fill and empties the pipeline.
// When the receiver stalls, the output register holds its beat and the
// stages behind it fill up before s_axis_tready drops.
module clipped_rectangle_fill_writer import crfw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// rect_x, rect_y, rect_width, rect_height, red, green, blue
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pixel_address, pixel_word
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t  cfg_q;
	logic  s2_valid;
	prep_t s2_item;
	logic  adv;
	logic  start_go;
	logic  emit;

	logic                active_q;
	logic [COORD_W-1:0]  cur_col_q;
	logic [COORD_W-1:0]  cur_row_q;
	logic [COORD_W-1:0]  first_col_q;
	logic [END_W-1:0]    end_col_q;
	logic [END_W-1:0]    end_row_q;
	logic [ADDR_W-1:0]   row_base_q;
	logic [WORD_W-1:0]   fill_word_q;

	logic [END_W-1:0]    next_col;
	logic [END_W-1:0]    next_row;
	logic                row_done;
	logic                last_w;
	logic [ADDR_W-1:0]   pix_addr;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [WORD_W-1:0]   out_word_q;
	logic                out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= '0;
			cfg_q.screen_width <= '0;
			cfg_q.screen_height <= '0;
			cfg_q.row_pitch <= '0;
			cfg_q.red_format <= RED_FORMAT_RST;
			cfg_q.green_format <= GREEN_FORMAT_RST;
			cfg_q.blue_format <= BLUE_FORMAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_ADDRESS:  cfg_q.base_address <= cfg_wdata[ADDR_W-1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width <= cfg_wdata[COORD_W-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[COORD_W-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch <= cfg_wdata[PITCH_W-1:0];
				REG_RED_FORMAT:    cfg_q.red_format <= cfg_wdata[FMT_W-1:0];
				REG_GREEN_FORMAT:  cfg_q.green_format <= cfg_wdata[FMT_W-1:0];
				REG_BLUE_FORMAT:   cfg_q.blue_format <= cfg_wdata[FMT_W-1:0];
				default: ;
			endcase
		end
	end

	crfw_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (s2_valid),
		.out_item  (s2_item),
		.out_take  (adv)
	);

	// walker stage moves whenever the output register is free or draining
	assign adv      = !out_valid_q || m_axis_tready;
	assign start_go = s2_valid && adv && !s2_item.is_tick;
	assign emit     = s2_valid && adv && s2_item.is_tick && active_q;

	// position of the current pixel and end of row / rectangle
	always_comb begin
		next_col = END_W'(cur_col_q) + END_W'(1);
		next_row = END_W'(cur_row_q) + END_W'(1);
		row_done = next_col >= end_col_q;
		last_w = row_done && (next_row >= end_row_q);
		pix_addr = row_base_q + ADDR_W'({cur_col_q, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= 1'b0;
		else if (start_go)
			active_q <= s2_item.start_ok;
		else if (emit && last_w)
			active_q <= 1'b0;
	end

	// fill walker registers
	always_ff @(posedge clk) begin
		if (start_go && s2_item.start_ok) begin
			cur_col_q <= s2_item.x;
			first_col_q <= s2_item.x;
			cur_row_q <= s2_item.y;
			end_col_q <= s2_item.end_col;
			end_row_q <= s2_item.end_row;
			row_base_q <= cfg_q.base_address + ADDR_W'(s2_item.y_pitch);
			fill_word_q <= s2_item.fill_word;
		end else if (emit) begin
			if (row_done) begin
				cur_col_q <= first_col_q;
				cur_row_q <= next_row[COORD_W-1:0];
				row_base_q <= row_base_q + ADDR_W'(cfg_q.row_pitch);
			end else begin
				cur_col_q <= next_col[COORD_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q <= pix_addr;
			out_word_q <= fill_word_q;
			out_last_q <= last_w;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_word_q, out_addr_q};
	assign m_axis_tlast  = out_last_q;

	// a fresh beat comes only from a tick that met a running fill
	a_beat_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s2_valid && adv && s2_item.is_tick && active_q))
		else $error("pixel beat without a tick on a running fill");

	// the final pixel ends the fill
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_w) |=> !active_q)
		else $error("fill still running after its last pixel");

	// a running fill stays inside its rectangle
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((END_W'(cur_col_q) < end_col_q) && (END_W'(cur_row_q) < end_row_q)))
		else $error("walker position outside the rectangle");

	// a start never produces a beat
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start_go |=> !out_valid_q)
		else $error("start item produced a pixel beat");

endmodule

### verif/pixel_write_checker.sv
`timescale 1ns / 1ps

module pixel_write_checker import crfw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// rect_x, rect_y, rect_width, rect_height, red, green, blue
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic                   s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// pixel_address, pixel_word
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output int                     mismatch_count,
	output int                     pending_writes,
	output int                     writes_checked
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] word;
		logic              last;
	} pixel_write_t;

	pixel_write_t expected_writes[$];

	// register copy and fill walker state
	cfg_t               regs;
	logic               fill_on;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] first_col;
	logic [END_W-1:0]   col_end;
	logic [END_W-1:0]   row_end;
	logic [ADDR_W-1:0]  row_addr;
	logic [WORD_W-1:0]  fill_pixel;
	int                 errors;
	int                 compared;

	// 8-bit intensity scaled to the mask size, then moved to its shift
	function automatic logic [WORD_W-1:0] color_field(input logic [CHAN_W-1:0] level,
			input logic [FMT_W-1:0] fmt);
		longint unsigned full_scale;
		longint unsigned scaled;
		full_scale = (64'd1 << fmt[4:0]) - 64'd1;
		scaled = 64'(level) * full_scale / 64'd255;
		return WORD_W'(scaled << fmt[9:5]);
	endfunction

	// advance the fill for one accepted beat, queueing the pixel write it causes
	function automatic void apply_item(input logic kind, input in_item_t it);
		logic [END_W-1:0] span_w;
		logic [END_W-1:0] span_h;
		logic             row_done;
		logic             last;
		pixel_write_t     px;
		if (kind == MODE_START) begin
			fill_on = 1'b0;
			if (it.rect_x >= regs.screen_width || it.rect_y >= regs.screen_height)
				return;
			span_w = END_W'(it.rect_width);
			span_h = END_W'(it.rect_height);
			if (span_w > END_W'(regs.screen_width - it.rect_x))
				span_w = END_W'(regs.screen_width - it.rect_x);
			if (span_h > END_W'(regs.screen_height - it.rect_y))
				span_h = END_W'(regs.screen_height - it.rect_y);
			if (span_w == '0 || span_h == '0)
				return;
			fill_pixel = color_field(it.red, regs.red_format)
				| color_field(it.green, regs.green_format)
				| color_field(it.blue, regs.blue_format);
			col = it.rect_x;
			first_col = it.rect_x;
			row = it.rect_y;
			col_end = END_W'(it.rect_x) + span_w;
			row_end = END_W'(it.rect_y) + span_h;
			row_addr = regs.base_address + ADDR_W'(it.rect_y) * ADDR_W'(regs.row_pitch);
			fill_on = 1'b1;
			return;
		end
		// a tick with no fill running is dropped
		if (!fill_on)
			return;
		row_done = (END_W'(col) + END_W'(1)) >= col_end;
		last = row_done && ((END_W'(row) + END_W'(1)) >= row_end);
		px.addr = row_addr + ADDR_W'({col, 2'b00});
		px.word = fill_pixel;
		px.last = last;
		expected_writes.push_back(px);
		if (row_done) begin
			col = first_col;
			row = row + COORD_W'(1);
			row_addr = row_addr + ADDR_W'(regs.row_pitch);
			if (last)
				fill_on = 1'b0;
		end else begin
			col = col + COORD_W'(1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_write_t got;
		pixel_write_t want;
		if (!arst_n) begin
			expected_writes.delete();
			regs = '0;
			regs.red_format = RED_FORMAT_RST;
			regs.green_format = GREEN_FORMAT_RST;
			regs.blue_format = BLUE_FORMAT_RST;
			fill_on = 1'b0;
			col = '0;
			row = '0;
			first_col = '0;
			col_end = '0;
			row_end = '0;
			row_addr = '0;
			fill_pixel = '0;
			errors = 0;
			compared = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_BASE_ADDRESS:  regs.base_address = cfg_wdata[ADDR_W-1:0];
					REG_SCREEN_WIDTH:  regs.screen_width = cfg_wdata[COORD_W-1:0];
					REG_SCREEN_HEIGHT: regs.screen_height = cfg_wdata[COORD_W-1:0];
					REG_ROW_PITCH:     regs.row_pitch = cfg_wdata[PITCH_W-1:0];
					REG_RED_FORMAT:    regs.red_format = cfg_wdata[FMT_W-1:0];
					REG_GREEN_FORMAT:  regs.green_format = cfg_wdata[FMT_W-1:0];
					REG_BLUE_FORMAT:   regs.blue_format = cfg_wdata[FMT_W-1:0];
					default: ;
				endcase
			end

			// accepted input beat
			if (s_axis_tvalid && s_axis_tready)
				apply_item(s_axis_tuser, in_item_t'(s_axis_tdata));

			// accepted pixel write against the oldest expectation
			if (m_axis_tvalid && m_axis_tready) begin
				got.addr = m_axis_tdata[ADDR_W-1:0];
				got.word = m_axis_tdata[ADDR_W +: WORD_W];
				got.last = m_axis_tlast;
				if (expected_writes.size() == 0) begin
					$error("pixel write with none expected: address %h, word %h, last %b",
						got.addr, got.word, got.last);
					errors++;
				end else begin
					want = expected_writes.pop_front();
					compared++;
					if (got.addr !== want.addr) begin
						$error("pixel_address: expected %h, got %h", want.addr, got.addr);
						errors++;
					end
					if (got.word !== want.word) begin
						$error("pixel_word: expected %h, got %h", want.word, got.word);
						errors++;
					end
					if (got.last !== want.last) begin
						$error("last_pixel: expected %b, got %b", want.last, got.last);
						errors++;
					end
				end
			end
		end
		mismatch_count <= errors;
		pending_writes <= expected_writes.size();
		writes_checked <= compared;
	end

endmodule

### verif/clipped_rectangle_fill_writer_test.sv
`timescale 1ns / 1ps

module clipped_rectangle_fill_writer_test;
	import crfw_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// rect_x, rect_y, rect_width, rect_height, red, green, blue
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// mode
	logic                   s_axis_tuser = MODE_TICK;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	// pixel_address, pixel_word
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_BASE_ADDRESS;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	int   mismatch_count;
	int   pending_writes;
	int   writes_checked;
	int   stall_pct = 0;
	int   gap_pct = 0;
	int   items_sent = 0;
	int   settings_used = 0;
	cfg_t screen;

	clipped_rectangle_fill_writer uut (.*);

	pixel_write_checker checker_i (.*);

	always #5 clk = ~clk;

	// receiver backpressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic kind, input logic [IN_TDATA_W-1:0] data);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= data;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		items_sent++;
	endtask

	// tick payload is ignored by the block, so fill it with noise
	task automatic send_tick();
		send_beat(MODE_TICK, IN_TDATA_W'({$urandom, $urandom, $urandom}));
	endtask

	task automatic send_start(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
			input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		in_item_t it;
		it.rect_x = x;
		it.rect_y = y;
		it.rect_width = w;
		it.rect_height = h;
		it.red = r;
		it.green = g;
		it.blue = b;
		send_beat(MODE_START, it);
	endtask

	// let every expected write drain, plus pipeline slack for starts and idle ticks
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		wait_idle();
		write_reg(REG_BASE_ADDRESS, CFG_DATA_W'(c.base_address));
		write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(c.screen_width));
		write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(c.screen_height));
		write_reg(REG_ROW_PITCH, CFG_DATA_W'(c.row_pitch));
		write_reg(REG_RED_FORMAT, CFG_DATA_W'(c.red_format));
		write_reg(REG_GREEN_FORMAT, CFG_DATA_W'(c.green_format));
		write_reg(REG_BLUE_FORMAT, CFG_DATA_W'(c.blue_format));
		cfg_we <= 1'b0;
		screen = c;
		settings_used++;
	endtask

	// none, sender idle, receiver stall, both
	task automatic set_idle(input int pattern);
		case (pattern)
			1: begin
				gap_pct = 74;
				stall_pct <= 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct <= 74;
			end
			3: begin
				gap_pct = 33;
				stall_pct <= 33;
			end
			default: begin
				gap_pct = 0;
				stall_pct <= 0;
			end
		endcase
	endtask

	function automatic logic [COORD_W-1:0] random_extent();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return '1;
		if (pick < 18)
			return '0;
		if (pick < 28)
			return COORD_W'(1);
		if (pick < 38)
			return COORD_W'($urandom);
		return COORD_W'($urandom_range(2, 24));
	endfunction

	function automatic logic [FMT_W-1:0] random_format();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return '1;
		if (pick < 25)
			return '0;
		return FMT_W'($urandom);
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		int   pick;
		c.base_address = ADDR_W'({$urandom, $urandom});
		c.screen_width = random_extent();
		c.screen_height = random_extent();
		pick = $urandom_range(99);
		if (pick < 15)
			c.row_pitch = '1;
		else if (pick < 25)
			c.row_pitch = '0;
		else
			c.row_pitch = PITCH_W'($urandom);
		c.red_format = random_format();
		c.green_format = random_format();
		c.blue_format = random_format();
		return c;
	endfunction

	// corner mostly on screen, often on the last column or row
	function automatic logic [COORD_W-1:0] pick_corner(input logic [COORD_W-1:0] extent);
		int pick;
		pick = $urandom_range(99);
		if (extent == '0 || pick < 8)
			return COORD_W'($urandom);
		if (pick < 28)
			return extent - COORD_W'(1);
		return COORD_W'($urandom_range(int'(extent) - 1));
	endfunction

	// mostly complete fills with random content, some cut short or overrun, some noise
	task automatic run_fills(input int budget);
		int                 stop_at;
		int                 pick;
		longint             cw;
		longint             ch;
		longint             pixels;
		longint             ticks;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_beat(MODE_START, IN_TDATA_W'({$urandom, $urandom, $urandom}));
			end else if (pick < 20) begin
				send_tick();
			end else begin
				x = pick_corner(screen.screen_width);
				y = pick_corner(screen.screen_height);
				w = ($urandom_range(9) == 0) ? '1 : COORD_W'($urandom_range(1, 6));
				h = ($urandom_range(9) == 0) ? '1 : COORD_W'($urandom_range(1, 4));
				send_start(x, y, w, h, CHAN_W'($urandom), CHAN_W'($urandom),
					CHAN_W'($urandom));
				cw = longint'(w);
				ch = longint'(h);
				if (x >= screen.screen_width)
					cw = 0;
				else if (cw > longint'(screen.screen_width) - longint'(x))
					cw = longint'(screen.screen_width) - longint'(x);
				if (y >= screen.screen_height)
					ch = 0;
				else if (ch > longint'(screen.screen_height) - longint'(y))
					ch = longint'(screen.screen_height) - longint'(y);
				pixels = cw * ch;
				pick = $urandom_range(99);
				if (pixels > 48)
					ticks = $urandom_range(8, 48);
				else if (pick < 15)
					ticks = $urandom_range(0, int'(pixels));
				else if (pick < 30)
					ticks = pixels + $urandom_range(1, 3);
				else
					ticks = pixels;
				repeat (ticks) send_tick();
			end
		end
	endtask

	initial begin
		cfg_t c;
		screen = '0;
		screen.red_format = RED_FORMAT_RST;
		screen.green_format = GREEN_FORMAT_RST;
		screen.blue_format = BLUE_FORMAT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: zero-size screen rejects every corner, idle tick emits nothing
		send_start('0, '0, COORD_W'(1), COORD_W'(1), 8'd255, 8'd255, 8'd255);
		send_tick();

		// small screen, 5-6-5 style formats, base near the top of the address space
		c.base_address = 48'hFFFF_FFFF_FFF0;
		c.screen_width = COORD_W'(5);
		c.screen_height = COORD_W'(3);
		c.row_pitch = PITCH_W'(256);
		c.red_format = {5'd11, 5'd5};
		c.green_format = {5'd5, 5'd6};
		c.blue_format = {5'd0, 5'd5};
		load_config(c);
		// zero width, zero height, idle tick, corner just past the right and bottom edge
		send_start('0, '0, '0, COORD_W'(2), 8'd1, 8'd1, 8'd1);
		send_start(COORD_W'(1), COORD_W'(1), COORD_W'(3), '0, 8'd1, 8'd1, 8'd1);
		send_tick();
		send_start(COORD_W'(5), '0, COORD_W'(1), COORD_W'(1), 8'd9, 8'd9, 8'd9);
		send_start('0, COORD_W'(3), COORD_W'(1), COORD_W'(1), 8'd9, 8'd9, 8'd9);
		// oversize rectangle clipped to 2x2, address wraps, then one idle tick
		send_start(COORD_W'(3), COORD_W'(1), '1, '1, 8'd255, 8'd128, 8'd0);
		repeat (5) send_tick();
		// full-screen clear interrupted by a single-pixel fill
		send_start('0, '0, COORD_W'(5), COORD_W'(3), 8'd0, 8'd255, 8'd1);
		repeat (2) send_tick();
		send_start(COORD_W'(4), COORD_W'(2), COORD_W'(1), COORD_W'(1), 8'd1, 8'd2, 8'd3);
		send_tick();

		// largest screen and pitch, widest formats, a zero-size channel
		c.base_address = '1;
		c.screen_width = '1;
		c.screen_height = '1;
		c.row_pitch = '1;
		c.red_format = '1;
		c.green_format = '0;
		c.blue_format = FMT_W'(31);
		load_config(c);
		send_start(16'hFFFE, 16'hFFFE, '1, '1, 8'd255, 8'd255, 8'd255);
		send_tick();
		send_start(16'hFFFF, '0, COORD_W'(1), COORD_W'(1), 8'd7, 8'd7, 8'd7);
		send_start('0, 16'hFFFE, COORD_W'(2), COORD_W'(5), 8'd128, 8'd64, 8'd32);
		repeat (2) send_tick();

		// random settings, rotating through the idling patterns
		for (int phase = 0; phase < 12; phase++) begin
			load_config(random_config());
			set_idle(phase % 4);
			run_fills(120);
		end

		wait_idle();
		$display("covered %0d stream beats under %0d register settings and four idling patterns",
			items_sent, settings_used + 1);
		$display("%0d pixel writes compared, %0d mismatches", writes_checked, mismatch_count);
		if (mismatch_count == 0 && pending_writes == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("run did not finish in time");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/crfw_pkg.sv
rtl/crfw_prep.sv
rtl/clipped_rectangle_fill_writer.sv
verif/pixel_write_checker.sv
verif/clipped_rectangle_fill_writer_test.sv
